/* sv/rwihl_pkg.sv */
package rwihl_pkg;

  localparam int unsigned ROM_DEPTH_DEF = 65536;
  localparam int unsigned OFF_W         = 16;
  localparam int unsigned EXT_W         = 17;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Opcodes of an input item
  localparam logic [2:0] OP_ERASE = 3'd0;
  localparam logic [2:0] OP_HEX   = 3'd1;
  localparam logic [2:0] OP_RAW   = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 1'd1;

  localparam logic [15:0] BASE_RST  = 16'hF800;
  localparam logic [8:0]  PAGES_RST = 9'd8;
  localparam logic [8:0]  PAGES_MAX = 9'd256;

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] KIND_DATA = 8'h00;
  localparam logic [7:0] KIND_EOF  = 8'h01;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_SKIP_LINE,
    PH_HEADER,
    PH_DATA,
    PH_CHECKSUM,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_STORE,
    CMD_READ,
    CMD_ERASE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CLEAR
  } back_state_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [OFF_W-1:0] off;
    logic [7:0]       data;
    logic             hit;
    logic [EXT_W-1:0] extent;
    logic             cerr;
    logic             eof;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic init;
    logic pop;
  } back_stat_t;

endpackage

/* sv/rwihl_ram.sv */
module rwihl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/rwihl_front.sv */
module rwihl_front #(
  parameter int unsigned ROM_DEPTH = rwihl_pkg::ROM_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [2:0]                     opcode,
  input  logic [7:0]                     char_or_byte,
  input  logic [15:0]                    bus_address,
  input  logic [15:0]                    base_address,
  input  logic [8:0]                     size_pages,
  output logic                           push,
  output rwihl_pkg::cmd_t                cmd
);

  localparam logic [rwihl_pkg::EXT_W-1:0] DEPTH_X = rwihl_pkg::EXT_W'(ROM_DEPTH);

  rwihl_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  nib_r, nib_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] raddr_r, raddr_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [3:0]  part_r, part_nxt;
  logic [rwihl_pkg::EXT_W-1:0] ext_r, ext_nxt;
  logic [rwihl_pkg::EXT_W-1:0] raw_r, raw_nxt;
  logic        eof_r, eof_nxt;

  logic        is_hex, is_space, is_colon, is_nl, hex_op;
  logic [3:0]  hex_v;
  logic [7:0]  kind_new, rec_byte, sum_add;
  logic [8:0]  idx_inc;
  logic [8:0]  pages_c;
  logic [rwihl_pkg::EXT_W-1:0] sz_raw, win_sz;
  logic [rwihl_pkg::EXT_W-1:0] abs_a, st_off, rd_off;
  logic        st_in, rd_hit;
  logic        cerr;

  // Classify the character
  always_comb begin
    is_hex = 1'b1;
    hex_v  = 4'd0;
    if (char_or_byte >= "0" && char_or_byte <= "9") begin
      hex_v = 4'(char_or_byte - "0");
    end else if (char_or_byte >= "A" && char_or_byte <= "F") begin
      hex_v = 4'(char_or_byte - "A" + 8'd10);
    end else if (char_or_byte >= "a" && char_or_byte <= "f") begin
      hex_v = 4'(char_or_byte - "a" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_space = (char_or_byte == rwihl_pkg::CH_SPACE) ||
                    (char_or_byte >= rwihl_pkg::CH_TAB && char_or_byte <= rwihl_pkg::CH_CR);
  assign is_colon = (char_or_byte == rwihl_pkg::CH_COLON);
  assign is_nl    = (char_or_byte == rwihl_pkg::CH_LF);
  assign hex_op   = accept && (opcode == rwihl_pkg::OP_HEX);

  assign kind_new = {kind_r[3:0], hex_v};
  assign rec_byte = {part_r, hex_v};
  assign sum_add  = sum_r + rec_byte;
  assign idx_inc  = {1'b0, idx_r} + 9'd1;

  // Window size, capped at the store depth
  assign pages_c = (size_pages > rwihl_pkg::PAGES_MAX) ? rwihl_pkg::PAGES_MAX : size_pages;
  assign sz_raw  = {pages_c, 8'h00};
  assign win_sz  = (sz_raw > DEPTH_X) ? DEPTH_X : sz_raw;

  // Window checks for a record byte and for a read
  assign abs_a  = {1'b0, raddr_r} + {9'd0, idx_r};
  assign st_off = abs_a - {1'b0, base_address};
  assign st_in  = (abs_a >= {1'b0, base_address}) && (st_off < win_sz);
  assign rd_off = {1'b0, bus_address - base_address};
  assign rd_hit = (bus_address >= base_address) && (rd_off < win_sz) && (rd_off < ext_r);

  // Parser next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept && opcode == rwihl_pkg::OP_ERASE) begin
      phase_nxt = rwihl_pkg::PH_LINE_START;
    end else if (hex_op) begin
      unique case (phase_r)
        rwihl_pkg::PH_DONE: phase_nxt = rwihl_pkg::PH_DONE;
        rwihl_pkg::PH_LINE_START: begin
          if (is_colon) begin
            phase_nxt = rwihl_pkg::PH_HEADER;
          end else if (!is_space) begin
            phase_nxt = rwihl_pkg::PH_SKIP_LINE;
          end
        end
        rwihl_pkg::PH_SKIP_LINE: begin
          if (is_nl) phase_nxt = rwihl_pkg::PH_LINE_START;
        end
        rwihl_pkg::PH_HEADER: begin
          if (is_nl) begin
            phase_nxt = rwihl_pkg::PH_LINE_START;
          end else if (!is_hex) begin
            phase_nxt = rwihl_pkg::PH_SKIP_LINE;
          end else if (nib_r == 3'd7) begin
            if (kind_new == rwihl_pkg::KIND_EOF) begin
              phase_nxt = rwihl_pkg::PH_DONE;
            end else if (kind_new != rwihl_pkg::KIND_DATA) begin
              phase_nxt = rwihl_pkg::PH_SKIP_LINE;
            end else if (len_r == 8'd0) begin
              phase_nxt = rwihl_pkg::PH_CHECKSUM;
            end else begin
              phase_nxt = rwihl_pkg::PH_DATA;
            end
          end
        end
        rwihl_pkg::PH_DATA: begin
          if (is_nl) begin
            phase_nxt = rwihl_pkg::PH_LINE_START;
          end else if (!is_hex) begin
            phase_nxt = rwihl_pkg::PH_SKIP_LINE;
          end else if (nib_r != 3'd0 && idx_inc >= {1'b0, len_r}) begin
            phase_nxt = rwihl_pkg::PH_CHECKSUM;
          end
        end
        rwihl_pkg::PH_CHECKSUM: begin
          if (is_nl) begin
            phase_nxt = rwihl_pkg::PH_LINE_START;
          end else if (!is_hex || nib_r != 3'd0) begin
            phase_nxt = rwihl_pkg::PH_SKIP_LINE;
          end
        end
        default: phase_nxt = rwihl_pkg::PH_LINE_START;
      endcase
    end
  end

  // Parser fields, loader counters and the command for the back part
  always_comb begin
    nib_nxt   = nib_r;
    len_nxt   = len_r;
    raddr_nxt = raddr_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    part_nxt  = part_r;
    ext_nxt   = ext_r;
    raw_nxt   = raw_r;
    eof_nxt   = eof_r;
    cerr      = 1'b0;
    cmd.kind  = rwihl_pkg::CMD_NONE;
    cmd.off   = '0;
    cmd.data  = rec_byte;
    cmd.hit   = 1'b0;
    if (accept) begin
      unique case (opcode)
        rwihl_pkg::OP_ERASE: begin
          nib_nxt   = '0;
          len_nxt   = '0;
          raddr_nxt = '0;
          kind_nxt  = '0;
          idx_nxt   = '0;
          sum_nxt   = '0;
          part_nxt  = '0;
          ext_nxt   = '0;
          raw_nxt   = '0;
          eof_nxt   = 1'b0;
          cmd.kind  = rwihl_pkg::CMD_ERASE;
        end
        rwihl_pkg::OP_HEX: begin
          if (phase_r == rwihl_pkg::PH_LINE_START && is_colon) begin
            nib_nxt   = '0;
            len_nxt   = '0;
            raddr_nxt = '0;
            kind_nxt  = '0;
          end else if (phase_r == rwihl_pkg::PH_HEADER && is_hex) begin
            if (nib_r < 3'd2) begin
              len_nxt = {len_r[3:0], hex_v};
            end else if (nib_r < 3'd6) begin
              raddr_nxt = {raddr_r[11:0], hex_v};
            end else begin
              kind_nxt = kind_new;
            end
            if (nib_r != 3'd7) begin
              nib_nxt = nib_r + 3'd1;
            end else begin
              nib_nxt = '0;
              sum_nxt = len_r + raddr_r[15:8] + raddr_r[7:0] + kind_new;
              idx_nxt = '0;
              if (kind_new == rwihl_pkg::KIND_EOF) eof_nxt = 1'b1;
            end
          end else if ((phase_r == rwihl_pkg::PH_DATA ||
                        phase_r == rwihl_pkg::PH_CHECKSUM) && is_hex) begin
            if (nib_r == 3'd0) begin
              part_nxt = hex_v;
              nib_nxt  = 3'd1;
            end else begin
              nib_nxt = '0;
              sum_nxt = sum_add;
              if (phase_r == rwihl_pkg::PH_DATA) begin
                idx_nxt = idx_inc[7:0];
                if (st_in) begin
                  cmd.kind = rwihl_pkg::CMD_STORE;
                  cmd.off  = st_off[rwihl_pkg::OFF_W-1:0];
                  if (st_off + 1'b1 > ext_r) ext_nxt = st_off + 1'b1;
                end
              end else begin
                cerr = (sum_add != 8'd0);
              end
            end
          end
        end
        rwihl_pkg::OP_RAW: begin
          if (raw_r < win_sz) begin
            cmd.kind = rwihl_pkg::CMD_STORE;
            cmd.off  = raw_r[rwihl_pkg::OFF_W-1:0];
            cmd.data = char_or_byte;
            raw_nxt  = raw_r + 1'b1;
            if (raw_r + 1'b1 > ext_r) ext_nxt = raw_r + 1'b1;
          end
        end
        rwihl_pkg::OP_READ: begin
          cmd.kind = rwihl_pkg::CMD_READ;
          cmd.off  = rd_off[rwihl_pkg::OFF_W-1:0];
          cmd.hit  = rd_hit;
        end
        default: cmd.kind = rwihl_pkg::CMD_NONE;
      endcase
    end
    cmd.extent = ext_nxt;
    cmd.cerr   = cerr;
    cmd.eof    = eof_nxt;
  end

  assign push = accept;

  // Hold parser and loader state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rwihl_pkg::PH_LINE_START;
      nib_r   <= '0;
      len_r   <= '0;
      raddr_r <= '0;
      kind_r  <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
      part_r  <= '0;
      ext_r   <= '0;
      raw_r   <= '0;
      eof_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
      len_r   <= len_nxt;
      raddr_r <= raddr_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      part_r  <= part_nxt;
      ext_r   <= ext_nxt;
      raw_r   <= raw_nxt;
      eof_r   <= eof_nxt;
    end
  end

endmodule

/* sv/rwihl_queue.sv */
module rwihl_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rwihl_pkg::cmd_t     push_cmd,
  input  logic                pop,
  output rwihl_pkg::cmd_t     head,
  output rwihl_pkg::q_stat_t  stat
);

  localparam int unsigned PW = $clog2(rwihl_pkg::QUEUE_DEPTH);

  rwihl_pkg::cmd_t slot_r [rwihl_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r, cnt_nxt;

  assign head       = slot_r[rp_r];
  assign stat.full  = (cnt_r == (PW+1)'(rwihl_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign cnt_nxt    = cnt_r + (PW+1)'(push) - (PW+1)'(pop);

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* sv/rwihl_back.sv */
module rwihl_back #(
  parameter int unsigned ROM_DEPTH = rwihl_pkg::ROM_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rwihl_pkg::cmd_t               head,
  input  logic                          head_valid,
  output rwihl_pkg::back_stat_t         stat,
  output logic                          out_valid,
  output logic [7:0]                    out_read_data,
  output logic [rwihl_pkg::EXT_W-1:0]   out_loaded_extent,
  output logic                          out_checksum_error,
  output logic                          out_hex_finished
);

  localparam int unsigned AW = $clog2(ROM_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(ROM_DEPTH - 1);

  rwihl_pkg::back_state_t state_r, state_nxt;
  rwihl_pkg::cmd_t held_r;
  logic [AW-1:0] clr_r;
  logic          init_r;
  logic          pop, clr_last;
  logic          d_we, v_we, v_wd;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    d_rd;
  logic          v_rd;
  logic          res_en;
  logic [7:0]    res_rd;
  rwihl_pkg::cmd_t res_src;
  logic          ov_r;
  logic [7:0]    ord_r;
  logic [rwihl_pkg::EXT_W-1:0] oext_r;
  logic          ocerr_r, oeof_r;

  assign pop      = (state_r == rwihl_pkg::BK_IDLE) && head_valid;
  assign clr_last = (clr_r == LAST);
  assign stat.init = init_r;
  assign stat.pop  = pop;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rwihl_pkg::BK_IDLE: begin
        if (pop && head.kind == rwihl_pkg::CMD_READ && head.hit) begin
          state_nxt = rwihl_pkg::BK_READ;
        end else if (pop && head.kind == rwihl_pkg::CMD_ERASE) begin
          state_nxt = rwihl_pkg::BK_CLEAR;
        end
      end
      rwihl_pkg::BK_READ:  state_nxt = rwihl_pkg::BK_IDLE;
      rwihl_pkg::BK_CLEAR: begin
        if (clr_last) state_nxt = rwihl_pkg::BK_IDLE;
      end
      default: state_nxt = rwihl_pkg::BK_IDLE;
    endcase
  end

  // Memory controls and result selection
  always_comb begin
    d_we    = 1'b0;
    v_we    = 1'b0;
    v_wd    = 1'b1;
    waddr   = head.off[AW-1:0];
    raddr   = head.off[AW-1:0];
    res_en  = 1'b0;
    res_rd  = 8'd0;
    res_src = head;
    unique case (state_r)
      rwihl_pkg::BK_IDLE: begin
        if (pop) begin
          if (head.kind == rwihl_pkg::CMD_STORE) begin
            d_we = 1'b1;
            v_we = 1'b1;
          end
          if (head.kind == rwihl_pkg::CMD_READ) begin
            res_en = !head.hit;
            res_rd = rwihl_pkg::BYTE_FF;
          end else begin
            res_en = (head.kind != rwihl_pkg::CMD_ERASE);
          end
        end
      end
      rwihl_pkg::BK_READ: begin
        res_en  = 1'b1;
        res_src = held_r;
        res_rd  = v_rd ? d_rd : rwihl_pkg::BYTE_FF;
      end
      rwihl_pkg::BK_CLEAR: begin
        v_we    = 1'b1;
        v_wd    = 1'b0;
        waddr   = clr_r;
        res_src = held_r;
        res_en  = clr_last && !init_r;
      end
      default: res_en = 1'b0;
    endcase
  end

  rwihl_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_data (
    .clk   (clk),
    .we    (d_we),
    .waddr (waddr),
    .wdata (head.data),
    .raddr (raddr),
    .rdata (d_rd)
  );

  rwihl_ram #(.WIDTH(1), .DEPTH(ROM_DEPTH)) u_valid (
    .clk   (clk),
    .we    (v_we),
    .waddr (waddr),
    .wdata (v_wd),
    .raddr (raddr),
    .rdata (v_rd)
  );

  // Hold the popped item while it is worked on, and register the result fields
  always_ff @(posedge clk) begin
    if (pop) held_r <= head;
    ord_r   <= res_rd;
    oext_r  <= res_src.extent;
    ocerr_r <= res_src.cerr;
    oeof_r  <= res_src.eof;
  end

  // Control state; a clearing pass runs after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rwihl_pkg::BK_CLEAR;
      clr_r   <= '0;
      init_r  <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= res_en;
      if (state_r == rwihl_pkg::BK_CLEAR) begin
        clr_r <= clr_last ? '0 : clr_r + 1'b1;
        if (clr_last) init_r <= 1'b0;
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_read_data      = ord_r;
  assign out_loaded_extent  = oext_r;
  assign out_checksum_error = ocerr_r;
  assign out_hex_finished   = oeof_r;

endmodule

/* sv/rom_with_intel_hex_loader.sv */
// Channel  | handshake                   | payload
// input    | start, busy                 | in_opcode, in_char_or_byte, in_bus_address
// result   | out_valid (one-cycle strobe) | out_read_data, out_loaded_extent,
//          |                             | out_checksum_error, out_hex_finished
// config   | cfg_valid, cfg_ready        | cfg_index, cfg_data
//
// A store or plain item passes the queue and the registered result stage; a read
// in the window also passes the registered read port of the store memories.
// Erase sweeps all ROM_DEPTH entries of the valid memory, one entry a cycle.
// After reset the same sweep runs with busy high.
// A two-item queue lets the front accept while the back clears or reads;
// busy rises when that queue is full. Results cannot be held off.
module rom_with_intel_hex_loader #(
  parameter int unsigned ROM_DEPTH = rwihl_pkg::ROM_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_opcode,
  input  logic [7:0]                        in_char_or_byte,
  input  logic [15:0]                       in_bus_address,
  output logic                              out_valid,
  output logic [7:0]                        out_read_data,
  output logic [rwihl_pkg::EXT_W-1:0]       out_loaded_extent,
  output logic                              out_checksum_error,
  output logic                              out_hex_finished,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rwihl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                       cfg_data
);

  logic [15:0] base_r;
  logic [8:0]  pages_r;
  logic        accept, push;
  rwihl_pkg::cmd_t       push_cmd, head;
  rwihl_pkg::q_stat_t    q_stat;
  rwihl_pkg::back_stat_t b_stat;

  assign cfg_ready = 1'b1;
  assign busy      = q_stat.full || b_stat.init;
  assign accept    = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= rwihl_pkg::BASE_RST;
      pages_r <= rwihl_pkg::PAGES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rwihl_pkg::CFG_BASE:  base_r  <= cfg_data;
        rwihl_pkg::CFG_PAGES: pages_r <= cfg_data[8:0];
        default: base_r <= base_r;
      endcase
    end
  end

  rwihl_front #(.ROM_DEPTH(ROM_DEPTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .opcode       (in_opcode),
    .char_or_byte (in_char_or_byte),
    .bus_address  (in_bus_address),
    .base_address (base_r),
    .size_pages   (pages_r),
    .push         (push),
    .cmd          (push_cmd)
  );

  rwihl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (b_stat.pop),
    .head     (head),
    .stat     (q_stat)
  );

  rwihl_back #(.ROM_DEPTH(ROM_DEPTH)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .head_valid         (!q_stat.empty),
    .stat               (b_stat),
    .out_valid          (out_valid),
    .out_read_data      (out_read_data),
    .out_loaded_extent  (out_loaded_extent),
    .out_checksum_error (out_checksum_error),
    .out_hex_finished   (out_hex_finished)
  );

  // An accepted item is waiting in the queue on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !q_stat.empty)
    else $error("accepted item missing from queue");

  // No pop from an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // No result while the start-up clearing pass runs
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(b_stat.init) && b_stat.init |-> !out_valid)
    else $error("result during start-up clear");

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rwihl_pkg::*;

  localparam logic [2:0] OP_WRITE = 3'd4;
  localparam logic [2:0] OP_LAST  = 3'd7;
  localparam int unsigned IMG_DEPTH = ROM_DEPTH_DEF;

  typedef struct {
    logic [7:0]       rdata;
    logic [EXT_W-1:0] extent;
    logic             cerr;
    logic             fin;
  } rom_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [2:0]           in_opcode;
  logic [7:0]           in_char_or_byte;
  logic [15:0]          in_bus_address;
  logic                 out_valid;
  logic [7:0]           out_read_data;
  logic [EXT_W-1:0]     out_loaded_extent;
  logic                 out_checksum_error;
  logic                 out_hex_finished;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // Mirror of the ROM and its loader
  bit [7:0]       img_byte [IMG_DEPTH];
  bit             img_set [IMG_DEPTH];
  phase_t         prs_phase;
  bit [2:0]       prs_nib;
  bit [7:0]       prs_len;
  bit [15:0]      prs_addr;
  bit [7:0]       prs_kind;
  bit [7:0]       prs_idx;
  bit [7:0]       prs_sum;
  bit [7:0]       prs_part;
  bit [EXT_W-1:0] img_extent;
  bit [EXT_W-1:0] raw_fill;
  bit             eof_flag;
  bit [15:0]      win_base;
  bit [8:0]       win_pages;

  rom_result_t pending_results[$];
  int          error_count;
  int          items_sent;
  int          gap_odds;
  bit          no_gaps;

  rom_with_intel_hex_loader DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_char_or_byte(in_char_or_byte),
    .in_bus_address(in_bus_address), .out_valid(out_valid),
    .out_read_data(out_read_data), .out_loaded_extent(out_loaded_extent),
    .out_checksum_error(out_checksum_error), .out_hex_finished(out_hex_finished),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned window_bytes();
    int unsigned p;
    p = (win_pages > 256) ? 256 : win_pages;
    return p * 256;
  endfunction

  function automatic void wipe_image();
    for (int i = 0; i < IMG_DEPTH; i++) img_set[i] = 1'b0;
    prs_phase  = PH_LINE_START;
    prs_nib    = '0;
    prs_len    = '0;
    prs_addr   = '0;
    prs_kind   = '0;
    prs_idx    = '0;
    prs_sum    = '0;
    prs_part   = '0;
    img_extent = '0;
    raw_fill   = '0;
    eof_flag   = 1'b0;
  endfunction

  function automatic int digit_value(bit [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  // Store a record byte if its absolute address falls in the window
  function automatic void place_byte(int unsigned abs_addr, bit [7:0] val);
    int unsigned off;
    if (abs_addr < win_base) return;
    off = abs_addr - win_base;
    if (off >= window_bytes()) return;
    img_byte[off] = val;
    img_set[off]  = 1'b1;
    if (off + 1 > img_extent) img_extent = off + 1;
  endfunction

  // Advance the record parser by one character; returns the checksum flag
  function automatic bit parse_char(bit [7:0] c);
    int      v;
    bit [7:0] b;
    if (prs_phase == PH_DONE) return 1'b0;
    if (prs_phase == PH_LINE_START) begin
      if (c == CH_COLON) begin
        prs_phase = PH_HEADER;
        prs_nib   = '0;
        prs_len   = '0;
        prs_addr  = '0;
        prs_kind  = '0;
      end else if (!(c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))) begin
        prs_phase = PH_SKIP_LINE;
      end
      return 1'b0;
    end
    if (c == CH_LF) begin
      prs_phase = PH_LINE_START;
      return 1'b0;
    end
    if (prs_phase == PH_SKIP_LINE) return 1'b0;
    v = digit_value(c);
    if (v < 0) begin
      prs_phase = PH_SKIP_LINE;
      return 1'b0;
    end
    if (prs_phase == PH_HEADER) begin
      if (prs_nib < 2) prs_len = {prs_len[3:0], 4'(v)};
      else if (prs_nib < 6) prs_addr = {prs_addr[11:0], 4'(v)};
      else prs_kind = {prs_kind[3:0], 4'(v)};
      if (prs_nib < 7) begin
        prs_nib++;
        return 1'b0;
      end
      prs_nib = '0;
      prs_sum = prs_len + prs_addr[15:8] + prs_addr[7:0] + prs_kind;
      prs_idx = '0;
      if (prs_kind == KIND_EOF) begin
        eof_flag  = 1'b1;
        prs_phase = PH_DONE;
      end else if (prs_kind != KIND_DATA) begin
        prs_phase = PH_SKIP_LINE;
      end else begin
        prs_phase = (prs_len == 0) ? PH_CHECKSUM : PH_DATA;
      end
      return 1'b0;
    end
    // data or checksum byte
    if (prs_nib == 0) begin
      prs_part = 8'(v);
      prs_nib  = 3'd1;
      return 1'b0;
    end
    prs_nib = '0;
    b = {prs_part[3:0], 4'(v)};
    prs_sum = prs_sum + b;
    if (prs_phase == PH_DATA) begin
      place_byte(int'(prs_addr) + int'(prs_idx), b);
      if (int'(prs_idx) + 1 >= int'(prs_len)) prs_phase = PH_CHECKSUM;
      prs_idx++;
      return 1'b0;
    end
    prs_phase = PH_SKIP_LINE;
    return prs_sum != 0;
  endfunction

  // Work out the result of one accepted item and queue it
  function automatic void predict_item(bit [2:0] op, bit [7:0] cb, bit [15:0] a);
    rom_result_t r;
    int unsigned off;
    r.rdata = 8'h00;
    r.cerr  = 1'b0;
    case (op)
      OP_ERASE: wipe_image();
      OP_HEX:   r.cerr = parse_char(cb);
      OP_RAW: begin
        if (raw_fill < window_bytes()) begin
          img_byte[raw_fill] = cb;
          img_set[raw_fill]  = 1'b1;
          raw_fill++;
          if (raw_fill > img_extent) img_extent = raw_fill;
        end
      end
      OP_READ: begin
        r.rdata = BYTE_FF;
        if (a >= win_base) begin
          off = a - win_base;
          if (off < window_bytes() && off < img_extent && img_set[off])
            r.rdata = img_byte[off];
        end
      end
      default: ;
    endcase
    r.extent = img_extent;
    r.fin    = eof_flag;
    pending_results.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    rom_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_loaded_extent, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_read_data !== e.rdata) report_mismatch("read_data", out_read_data, e.rdata);
        if (out_loaded_extent !== e.extent)
          report_mismatch("loaded_extent", out_loaded_extent, e.extent);
        if (out_checksum_error !== e.cerr)
          report_mismatch("checksum_error", out_checksum_error, e.cerr);
        if (out_hex_finished !== e.fin)
          report_mismatch("hex_finished", out_hex_finished, e.fin);
      end
    end
  end

  // Send one item, at times with a random idle burst ahead of it
  task automatic send_item(bit [2:0] op, bit [7:0] cb, bit [15:0] a);
    if (items_sent % 64 == 0) gap_odds = $urandom_range(0, 3);
    if (!no_gaps && gap_odds != 0 && $urandom_range(0, 9) < gap_odds) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_char_or_byte <= cb;
    in_bus_address  <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(op, cb, a);
    items_sent++;
  endtask

  task automatic send_char(bit [7:0] c);
    send_item(OP_HEX, c, 16'($urandom));
  endtask

  function automatic bit [7:0] digit_char(bit [3:0] v, bit upper);
    if (v < 10) return 8'("0") + v;
    return 8'((upper ? 8'("A") : 8'("a")) + v - 10);
  endfunction

  task automatic send_hex_byte(bit [7:0] b);
    bit up;
    up = $urandom_range(0, 1);
    send_char(digit_char(b[7:4], up));
    send_char(digit_char(b[3:0], up));
  endtask

  // Send one record line; a fault cuts it with a newline or a stray character
  task automatic send_record(bit [7:0] kind, int len, bit [15:0] addr,
                             bit bad_sum, bit fault);
    bit [7:0] rec[$];
    bit [7:0] sum;
    int       cut;
    rec = '{8'(len), addr[15:8], addr[7:0], kind};
    for (int i = 0; i < len; i++) rec.push_back(8'($urandom));
    sum = 0;
    foreach (rec[i]) sum += rec[i];
    sum = -sum;
    if (bad_sum) sum += 8'($urandom_range(1, 255));
    rec.push_back(sum);
    cut = fault ? $urandom_range(0, rec.size() - 1) : -1;
    repeat ($urandom_range(0, 2)) send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    send_char(CH_COLON);
    foreach (rec[i]) begin
      if (i == cut) begin
        send_char($urandom_range(0, 1) ? CH_LF : 8'("G"));
        if ($urandom_range(0, 1)) send_char(CH_LF);
        return;
      end
      send_hex_byte(rec[i]);
    end
    if ($urandom_range(0, 1)) send_char(CH_CR);
    send_char(CH_LF);
  endtask

  // Stop sending and let every expected result arrive
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(bit [CFG_IDX_W-1:0] idx, bit [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_BASE) win_base = val;
    else win_pages = val[8:0];
  endtask

  task automatic set_window(bit [15:0] b, bit [8:0] p);
    drain_results();
    write_register(CFG_BASE, b);
    write_register(CFG_PAGES, 16'(p));
    cfg_valid <= 1'b0;
  endtask

  // Mixed random traffic: records, mostly well-formed and aimed at the window, with reads, raw bytes and stray items
  task automatic random_traffic(int n);
    int       stop_at;
    int       pick;
    int       len;
    bit [15:0] a;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        a = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                      : 16'(win_base + $urandom_range(0, window_bytes() - 1));
        send_record($urandom_range(0, 7) == 0 ? 8'($urandom_range(2, 5)) : KIND_DATA,
                    len, a, $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
      end else if (pick < 75) begin
        a = $urandom_range(0, 4) == 0 ? 16'($urandom)
                                      : 16'(win_base + $urandom_range(0, img_extent + 4));
        send_item(OP_READ, 8'($urandom), a);
      end else if (pick < 87) begin
        send_item(OP_RAW, 8'($urandom), 16'($urandom));
      end else if (pick < 95) begin
        send_char(8'($urandom));
      end else if (pick < 99) begin
        send_item(3'($urandom_range(OP_WRITE, OP_LAST)), 8'($urandom), 16'($urandom));
      end else begin
        send_record(KIND_EOF, 0, 16'($urandom), 1'b0, 1'b0);
      end
    end
  endtask

  // Default window: every opcode and each parser corner
  task automatic test_directed();
    send_item(OP_READ, 8'h00, 16'hF800);
    send_item(OP_RAW, 8'hFF, 16'hFFFF);
    send_item(OP_RAW, 8'h00, 16'h0000);
    send_item(OP_READ, 8'h00, 16'hF800);
    send_item(OP_READ, 8'h00, 16'hF801);
    send_item(OP_READ, 8'h00, 16'hF7FF);
    send_record(KIND_DATA, 2, 16'hF810, 1'b0, 1'b0);
    send_item(OP_READ, 8'h00, 16'hF810);
    send_item(OP_READ, 8'h00, 16'hF811);
    send_record(KIND_DATA, 1, 16'hFFFF, 1'b1, 1'b0);
    send_record(KIND_DATA, 0, 16'h0000, 1'b0, 1'b0);
    send_record(8'h04, 2, 16'hF800, 1'b0, 1'b0);
    send_char("x");
    send_char(CH_COLON);
    send_char(CH_LF);
    send_record(KIND_DATA, 3, 16'hF820, 1'b0, 1'b1);
    send_item(OP_WRITE, 8'hFF, 16'hF800);
    send_item(OP_LAST, 8'h55, 16'hFFFF);
    send_record(KIND_DATA, 2, 16'h0100, 1'b0, 1'b0);
    send_record(KIND_EOF, 0, 16'h0000, 1'b0, 1'b0);
    send_record(KIND_DATA, 2, 16'hF830, 1'b0, 1'b0);
    send_item(OP_READ, 8'h00, 16'hF830);
    send_item(OP_ERASE, 8'h00, 16'h0000);
    send_item(OP_READ, 8'h00, 16'hF810);
    send_record(KIND_DATA, 4, 16'hF840, 1'b0, 1'b0);
  endtask

  // Window extremes, each from a fresh erase
  task automatic test_windows();
    set_window(16'h0000, PAGES_MAX);
    send_item(OP_ERASE, 8'h00, 16'h0000);
    send_record(KIND_DATA, 2, 16'hFFFF, 1'b0, 1'b0);
    send_item(OP_READ, 8'h00, 16'hFFFF);
    random_traffic(100);
    set_window(16'hFFFF, 9'd1);
    send_item(OP_ERASE, 8'h00, 16'h0000);
    send_record(KIND_DATA, 4, 16'hFFFE, 1'b0, 1'b0);
    repeat (260) send_item(OP_RAW, 8'($urandom), 16'($urandom));
    send_item(OP_READ, 8'h00, 16'hFFFF);
    random_traffic(60);
    set_window(16'hFF00, PAGES_MAX);
    send_item(OP_ERASE, 8'h00, 16'h0000);
    random_traffic(100);
  endtask

  // Random windows; the last phase runs without idle bursts
  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      set_window(16'($urandom), 9'($urandom_range(1, 256)));
      send_item(OP_ERASE, 8'h00, 16'h0000);
      if (ph == 3) no_gaps = 1'b1;
      random_traffic(200);
      // move the window after loading and read through it
      set_window(16'($urandom), 9'($urandom_range(1, 16)));
      random_traffic(30);
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_opcode       <= OP_ERASE;
    in_char_or_byte <= '0;
    in_bus_address  <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_BASE;
    cfg_data        <= '0;
    win_base    = BASE_RST;
    win_pages   = PAGES_RST;
    error_count = 0;
    items_sent  = 0;
    gap_odds    = 0;
    no_gaps     = 1'b0;
    wipe_image();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_windows();
    test_random();
    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
